// ===== rtl/dmac_pkg.sv =====
// ----------------------------------------------------------------------------
// dmac_pkg
// Shared types and constants of the two-channel chained dma controller.
// ----------------------------------------------------------------------------
package dmac_pkg;

  localparam int NUM_CHANNELS = 2;
  localparam int CTL_W        = 8;
  localparam int ADDR_W       = 16;
  localparam int CNT_W        = 11;
  localparam int DATA_W       = 8;
  localparam int OFF_W        = 4;
  localparam int PERIPH_W     = 4;

  // control byte bit positions
  localparam int CTL_EN_BIT    = 0;
  localparam int CTL_REQ_BIT   = 1;
  localparam int CTL_TOMEM_BIT = 2;
  localparam int CTL_EO_BIT    = 3;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_REQ   = 2'd2,
    OP_BEAT  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    SEL_CTL     = 3'd0,
    SEL_ADDR_LO = 3'd1,
    SEL_ADDR_HI = 3'd2,
    SEL_CNT_LO  = 3'd3,
    SEL_CNT_HI  = 3'd4
  } reg_sel_t;

  typedef struct packed {
    opcode_t              op;
    logic [OFF_W-1:0]     reg_offset;
    logic [DATA_W-1:0]    write_data;
    logic                 req_channel;
    logic                 req_level;
  } item_t;

  // request level lives in control bit 1
  typedef struct packed {
    logic [CTL_W-1:0]  ctl;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  cnt;
  } chan_t;

  typedef struct packed {
    logic [DATA_W-1:0]   read_data;
    logic                request_edge;
    logic                xfer_valid;
    logic                xfer_channel;
    logic                xfer_to_memory;
    logic [PERIPH_W-1:0] xfer_peripheral;
    logic [ADDR_W-1:0]   xfer_address;
    logic [CNT_W-1:0]    xfer_count_before;
    logic                done_irq;
    logic                last;
  } result_t;

  typedef struct packed {
    logic push;
    logic two;
  } q_ctl_t;

endpackage

// ===== rtl/dmac_exec.sv =====
// ----------------------------------------------------------------------------
// dmac_exec
// Combinational execution of one request against the channel registers.
// ----------------------------------------------------------------------------
module dmac_exec (
  input  dmac_pkg::item_t                           item,
  input  dmac_pkg::chan_t [dmac_pkg::NUM_CHANNELS-1:0] chan_cur,
  output dmac_pkg::chan_t [dmac_pkg::NUM_CHANNELS-1:0] chan_nxt,
  output dmac_pkg::result_t                         res_a,
  output dmac_pkg::result_t                         res_b,
  output logic                                      res_two
);

  function automatic dmac_pkg::result_t make_desc(input logic ch, input dmac_pkg::chan_t c,
                                                  input logic done, input logic lst);
    dmac_pkg::result_t r;
    r                   = '0;
    r.xfer_valid        = 1'b1;
    r.xfer_channel      = ch;
    r.xfer_to_memory    = c.ctl[dmac_pkg::CTL_TOMEM_BIT];
    r.xfer_peripheral   = c.ctl[dmac_pkg::CTL_W-1 -: dmac_pkg::PERIPH_W];
    r.xfer_address      = c.addr;
    r.xfer_count_before = c.cnt;
    r.done_irq          = done;
    r.last              = lst;
    return r;
  endfunction

  always_comb begin
    logic                ch;
    dmac_pkg::reg_sel_t  sel;
    dmac_pkg::chan_t     c0;
    dmac_pkg::chan_t     c1;
    dmac_pkg::chan_t     s0;
    dmac_pkg::chan_t     s1;
    logic                go0;
    logic                go1;
    logic                done0;
    logic                done1;

    ch       = item.reg_offset[dmac_pkg::OFF_W-1];
    sel      = dmac_pkg::reg_sel_t'(item.reg_offset[dmac_pkg::OFF_W-2:0]);
    chan_nxt = chan_cur;
    res_a    = '0;
    res_a.last = 1'b1;
    res_b    = '0;
    res_two  = 1'b0;
    c0 = chan_cur[0];
    c1 = chan_cur[1];
    s0 = c0;
    s1 = c1;
    go0 = 1'b0;
    go1 = 1'b0;
    done0 = 1'b0;
    done1 = 1'b0;

    unique case (item.op)
      dmac_pkg::OP_READ: begin
        unique case (sel)
          dmac_pkg::SEL_CTL:     res_a.read_data = chan_cur[ch].ctl;
          dmac_pkg::SEL_ADDR_LO: res_a.read_data = chan_cur[ch].addr[7:0];
          dmac_pkg::SEL_ADDR_HI: res_a.read_data = chan_cur[ch].addr[15:8];
          dmac_pkg::SEL_CNT_LO:  res_a.read_data = chan_cur[ch].cnt[7:0];
          dmac_pkg::SEL_CNT_HI:  res_a.read_data = {5'd0, chan_cur[ch].cnt[10:8]};
          default:               res_a.read_data = '0;
        endcase
      end
      dmac_pkg::OP_WRITE: begin
        unique case (sel)
          dmac_pkg::SEL_CTL: begin
            // request bit is owned by the request line
            chan_nxt[ch].ctl = item.write_data;
            chan_nxt[ch].ctl[dmac_pkg::CTL_REQ_BIT] = chan_cur[ch].ctl[dmac_pkg::CTL_REQ_BIT];
          end
          dmac_pkg::SEL_ADDR_LO: chan_nxt[ch].addr[7:0]  = item.write_data;
          dmac_pkg::SEL_ADDR_HI: chan_nxt[ch].addr[15:8] = item.write_data;
          dmac_pkg::SEL_CNT_LO:  chan_nxt[ch].cnt[7:0]   = item.write_data;
          dmac_pkg::SEL_CNT_HI:  chan_nxt[ch].cnt[10:8]  = item.write_data[2:0];
          default: ;
        endcase
      end
      dmac_pkg::OP_REQ: begin
        res_a.request_edge =
          chan_cur[item.req_channel].ctl[dmac_pkg::CTL_REQ_BIT] != item.req_level;
        chan_nxt[item.req_channel].ctl[dmac_pkg::CTL_REQ_BIT] = item.req_level;
      end
      dmac_pkg::OP_BEAT: begin
        // channel 0 first
        go0 = c0.ctl[dmac_pkg::CTL_EN_BIT] && c0.ctl[dmac_pkg::CTL_REQ_BIT] && (c0.cnt != '0);
        if (go0) begin
          done0  = (c0.cnt == dmac_pkg::CNT_W'(1));
          s0.addr = c0.addr + dmac_pkg::ADDR_W'(1);
          s0.cnt  = c0.cnt - dmac_pkg::CNT_W'(1);
          if (done0) begin
            s0.ctl[dmac_pkg::CTL_EN_BIT] = 1'b0;
            if (s1.ctl[dmac_pkg::CTL_EO_BIT]) s1.ctl[dmac_pkg::CTL_EN_BIT] = 1'b1;
          end
        end
        // channel 1 sees a chained enable from channel 0
        go1 = s1.ctl[dmac_pkg::CTL_EN_BIT] && s1.ctl[dmac_pkg::CTL_REQ_BIT] && (s1.cnt != '0);
        if (go1) begin
          done1   = (s1.cnt == dmac_pkg::CNT_W'(1));
          s1.addr = s1.addr + dmac_pkg::ADDR_W'(1);
          s1.cnt  = s1.cnt - dmac_pkg::CNT_W'(1);
          if (done1) begin
            s1.ctl[dmac_pkg::CTL_EN_BIT] = 1'b0;
            if (s0.ctl[dmac_pkg::CTL_EO_BIT]) s0.ctl[dmac_pkg::CTL_EN_BIT] = 1'b1;
          end
        end
        chan_nxt[0] = s0;
        chan_nxt[1] = s1;
        // a chained enable touches only the enable bit, so the descriptor
        // fields of channel 1 come straight from its current registers
        if (go0 && go1) begin
          res_a   = make_desc(1'b0, c0, done0, 1'b0);
          res_b   = make_desc(1'b1, c1, done1, 1'b1);
          res_two = 1'b1;
        end else if (go0) begin
          res_a = make_desc(1'b0, c0, done0, 1'b1);
        end else if (go1) begin
          res_a = make_desc(1'b1, c1, done1, 1'b1);
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/dmac_outq.sv =====
// ----------------------------------------------------------------------------
// dmac_outq
// Result register with one extra slot for the second descriptor of a beat.
// ----------------------------------------------------------------------------
module dmac_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  dmac_pkg::q_ctl_t  qctl,
  input  dmac_pkg::result_t res_a,
  input  dmac_pkg::result_t res_b,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output dmac_pkg::result_t out_res
);

  logic              out_v_r,  out_v_nxt;
  logic              pend_v_r, pend_v_nxt;
  dmac_pkg::result_t out_d_r,  out_d_nxt;
  dmac_pkg::result_t pend_d_r, pend_d_nxt;

  assign free      = !pend_v_r && (!out_v_r || out_ready);
  assign out_valid = out_v_r;
  assign out_res   = out_d_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    pend_v_nxt = pend_v_r;
    out_d_nxt  = out_d_r;
    pend_d_nxt = pend_d_r;
    if (qctl.push) begin
      out_v_nxt  = 1'b1;
      out_d_nxt  = res_a;
      pend_v_nxt = qctl.two;
      pend_d_nxt = res_b;
    end else if (out_v_r && out_ready) begin
      out_v_nxt  = pend_v_r;
      out_d_nxt  = pend_d_r;
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      pend_v_r <= pend_v_nxt;
    end
    out_d_r  <= out_d_nxt;
    pend_d_r <= pend_d_nxt;
  end

endmodule

// ===== rtl/two_channel_chained_dma_controller.sv =====
// ----------------------------------------------------------------------------
// two_channel_chained_dma_controller
// Two-channel dma controller with register access, request lines and
// chained channel enables; one request is executed per cycle unless stalled.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake             payload
//   in_       input       in_valid/in_ready     opcode, offset, data, request line
//   out_      output      out_valid/out_ready   read data, edge, transfer descriptor
//
// one request per cycle unless stalled: an input register holds the request, the
// channel registers are read and updated by single-pass logic when it moves on
// a beat with both channels transferring yields two results; the second one
// waits in a spare slot and holds off the next request until it moves into the result register
// reset (rst_n low, synchronous) clears all channel registers and the result slots
// out_ready low stalls the result register, then the input register, then in_ready
// ----------------------------------------------------------------------------
module two_channel_chained_dma_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_opcode,
  input  logic [dmac_pkg::OFF_W-1:0]       in_reg_offset,
  input  logic [dmac_pkg::DATA_W-1:0]      in_write_data,
  input  logic                             in_req_channel,
  input  logic                             in_req_level,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [dmac_pkg::DATA_W-1:0]      out_read_data,
  output logic                             out_request_edge,
  output logic                             out_xfer_valid,
  output logic                             out_xfer_channel,
  output logic                             out_xfer_to_memory,
  output logic [dmac_pkg::PERIPH_W-1:0]    out_xfer_peripheral,
  output logic [dmac_pkg::ADDR_W-1:0]      out_xfer_address,
  output logic [dmac_pkg::CNT_W-1:0]       out_xfer_count_before,
  output logic                             out_done_irq,
  output logic                             out_last
);

  // input register stage
  logic                  stg_valid_r, stg_valid_nxt;
  dmac_pkg::item_t       stg_item_r,  stg_item_nxt;
  logic                  stg_move;

  // channel registers (control, address, count per channel)
  dmac_pkg::chan_t [dmac_pkg::NUM_CHANNELS-1:0] chan_r, chan_nxt, chan_upd;

  dmac_pkg::result_t     res_a, res_b, out_res;
  logic                  res_two;
  logic                  q_free;
  dmac_pkg::q_ctl_t      qctl;

  // stage moves when the result side can take everything it produces
  assign stg_move = stg_valid_r && q_free;
  assign in_ready = !stg_valid_r || q_free;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    stg_item_nxt  = stg_item_r;
    if (in_valid && in_ready) begin
      stg_valid_nxt          = 1'b1;
      stg_item_nxt.op         = dmac_pkg::opcode_t'(in_opcode);
      stg_item_nxt.reg_offset = in_reg_offset;
      stg_item_nxt.write_data = in_write_data;
      stg_item_nxt.req_channel = in_req_channel;
      stg_item_nxt.req_level  = in_req_level;
    end else if (stg_move) begin
      stg_valid_nxt = 1'b0;
    end
  end

  // channel state changes only when its request retires into the result slots
  assign chan_nxt = stg_move ? chan_upd : chan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      chan_r      <= '0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      chan_r      <= chan_nxt;
    end
    stg_item_r <= stg_item_nxt;
  end

  dmac_exec u_exec (
    .item     (stg_item_r),
    .chan_cur (chan_r),
    .chan_nxt (chan_upd),
    .res_a    (res_a),
    .res_b    (res_b),
    .res_two  (res_two)
  );

  assign qctl.push = stg_move;
  assign qctl.two  = res_two;

  dmac_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .qctl      (qctl),
    .res_a     (res_a),
    .res_b     (res_b),
    .free      (q_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // unpack the presented result
  assign out_read_data         = out_res.read_data;
  assign out_request_edge      = out_res.request_edge;
  assign out_xfer_valid        = out_res.xfer_valid;
  assign out_xfer_channel      = out_res.xfer_channel;
  assign out_xfer_to_memory    = out_res.xfer_to_memory;
  assign out_xfer_peripheral   = out_res.xfer_peripheral;
  assign out_xfer_address      = out_res.xfer_address;
  assign out_xfer_count_before = out_res.xfer_count_before;
  assign out_done_irq          = out_res.done_irq;
  assign out_last              = out_res.last;

`ifndef SYNTH
  // a two-descriptor beat shows its first, non-final descriptor next
  a_two_first: assert property (@(posedge clk) disable iff (!rst_n)
    stg_move && res_two |=> out_valid && out_xfer_valid && !out_last && !out_xfer_channel)
    else $error("two-descriptor beat not presented in channel order");

  // a channel with zero count never transfers
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_xfer_valid |-> out_xfer_count_before != '0)
    else $error("transfer descriptor with zero count");

  // done interrupt only on the transfer that empties the channel
  a_done_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_irq |-> out_xfer_valid && out_xfer_count_before == 11'd1)
    else $error("done interrupt without final transfer");
`endif

endmodule

// ===== tb/two_channel_chained_dma_controller_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_channel_chained_dma_controller_checker
// Watches both channels of the dma controller. It keeps its own copy of the
// channel registers, works out the results of every accepted request and
// compares each returned result, field by field, in order.
// ----------------------------------------------------------------------------
module two_channel_chained_dma_controller_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [1:0]                    in_opcode,
  input  logic [dmac_pkg::OFF_W-1:0]    in_reg_offset,
  input  logic [dmac_pkg::DATA_W-1:0]   in_write_data,
  input  logic                          in_req_channel,
  input  logic                          in_req_level,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [dmac_pkg::DATA_W-1:0]   out_read_data,
  input  logic                          out_request_edge,
  input  logic                          out_xfer_valid,
  input  logic                          out_xfer_channel,
  input  logic                          out_xfer_to_memory,
  input  logic [dmac_pkg::PERIPH_W-1:0] out_xfer_peripheral,
  input  logic [dmac_pkg::ADDR_W-1:0]   out_xfer_address,
  input  logic [dmac_pkg::CNT_W-1:0]    out_xfer_count_before,
  input  logic                          out_done_irq,
  input  logic                          out_last,
  output int                            mismatches,
  output int                            outstanding
);
  import dmac_pkg::*;

  localparam int MAX_REPORTS = 60;

  logic [CTL_W-1:0]  ctl_reg  [NUM_CHANNELS];
  logic [ADDR_W-1:0] addr_reg [NUM_CHANNELS];
  logic [CNT_W-1:0]  cnt_reg  [NUM_CHANNELS];
  logic              req_line [NUM_CHANNELS];
  result_t           results_due [$];
  int                results_checked;

  initial begin
    mismatches      = 0;
    outstanding     = 0;
    results_checked = 0;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $time, what);
    end else if (mismatches == MAX_REPORTS + 1) begin
      $display("[%0t] mismatch: further reports suppressed", $time);
    end
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                results_checked, name, got, want));
    end
  endtask

  // applies one request to the register copy and queues what it returns
  task automatic execute_dma_request(input logic [1:0] opc, input logic [OFF_W-1:0] off,
                                     input logic [DATA_W-1:0] data, input logic rc,
                                     input logic lvl);
    result_t          res;
    result_t          xfer;
    result_t          xfers [NUM_CHANNELS];
    logic             ch;
    logic [2:0]       sel;
    logic [CTL_W-1:0] ctl_new;
    int               n;
    int               i;
    ch       = off[OFF_W-1];
    sel      = off[2:0];
    n        = 0;
    res      = '0;
    res.last = 1'b1;
    case (opcode_t'(opc))
      OP_READ: begin
        case (sel)
          SEL_CTL:     res.read_data = ctl_reg[ch];
          SEL_ADDR_LO: res.read_data = addr_reg[ch][7:0];
          SEL_ADDR_HI: res.read_data = addr_reg[ch][15:8];
          SEL_CNT_LO:  res.read_data = cnt_reg[ch][7:0];
          SEL_CNT_HI:  res.read_data = {5'b0, cnt_reg[ch][10:8]};
          default:     res.read_data = '0;
        endcase
      end
      OP_WRITE: begin
        case (sel)
          SEL_CTL: begin
            // the request bit only follows the request line
            ctl_new              = data;
            ctl_new[CTL_REQ_BIT] = ctl_reg[ch][CTL_REQ_BIT];
            ctl_reg[ch]          = ctl_new;
          end
          SEL_ADDR_LO: addr_reg[ch][7:0]  = data;
          SEL_ADDR_HI: addr_reg[ch][15:8] = data;
          SEL_CNT_LO:  cnt_reg[ch][7:0]   = data;
          SEL_CNT_HI:  cnt_reg[ch][10:8]  = data[2:0];
          default: ;
        endcase
      end
      OP_REQ: begin
        res.request_edge         = (req_line[rc] != lvl);
        req_line[rc]             = lvl;
        ctl_reg[rc][CTL_REQ_BIT] = lvl;
      end
      OP_BEAT: begin
        // channel 0 first, so a chain from 0 lets 1 run in the same beat
        for (i = 0; i < NUM_CHANNELS; i++) begin
          if (ctl_reg[i][CTL_EN_BIT] && req_line[i] && cnt_reg[i] != '0) begin
            xfer                   = '0;
            xfer.xfer_valid        = 1'b1;
            xfer.xfer_channel      = (i == 1);
            xfer.xfer_to_memory    = ctl_reg[i][CTL_TOMEM_BIT];
            xfer.xfer_peripheral   = ctl_reg[i][CTL_W-1 -: PERIPH_W];
            xfer.xfer_address      = addr_reg[i];
            xfer.xfer_count_before = cnt_reg[i];
            addr_reg[i]            = addr_reg[i] + 1'b1;
            cnt_reg[i]             = cnt_reg[i] - 1'b1;
            if (cnt_reg[i] == '0) begin
              ctl_reg[i][CTL_EN_BIT] = 1'b0;
              if (ctl_reg[1 - i][CTL_EO_BIT]) begin
                ctl_reg[1 - i][CTL_EN_BIT] = 1'b1;
              end
              xfer.done_irq = 1'b1;
            end
            xfers[n] = xfer;
            n++;
          end
        end
      end
      default: ;
    endcase
    if (n == 0) begin
      results_due.push_back(res);
    end
    for (i = 0; i < n; i++) begin
      xfer      = xfers[i];
      xfer.last = (i == n - 1);
      results_due.push_back(xfer);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      foreach (ctl_reg[k]) begin
        ctl_reg[k]  = '0;
        addr_reg[k] = '0;
        cnt_reg[k]  = '0;
        req_line[k] = 1'b0;
      end
      results_due.delete();
    end else begin
      // results first: a request taken at this edge cannot answer at it
      if (out_valid && out_ready) begin
        results_checked++;
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected (xfer %0b, data 0x%0h)",
                                    results_checked, out_xfer_valid, out_read_data));
        end else begin
          want = results_due.pop_front();
          compare_field("read_data", out_read_data, want.read_data);
          compare_field("request_edge", out_request_edge, want.request_edge);
          compare_field("xfer_valid", out_xfer_valid, want.xfer_valid);
          compare_field("xfer_channel", out_xfer_channel, want.xfer_channel);
          compare_field("xfer_to_memory", out_xfer_to_memory, want.xfer_to_memory);
          compare_field("xfer_peripheral", out_xfer_peripheral, want.xfer_peripheral);
          compare_field("xfer_address", out_xfer_address, want.xfer_address);
          compare_field("xfer_count_before", out_xfer_count_before, want.xfer_count_before);
          compare_field("done_irq", out_done_irq, want.done_irq);
          compare_field("last", out_last, want.last);
        end
      end
      if (in_valid && in_ready) begin
        execute_dma_request(in_opcode, in_reg_offset, in_write_data,
                            in_req_channel, in_req_level);
      end
    end
    outstanding = results_due.size();
  end

endmodule

// ===== tb/two_channel_chained_dma_controller_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_channel_chained_dma_controller_tb
// Drives register reads and writes, request line changes and transfer beats
// into the dma controller, with random gaps and result stalls, and gives the
// verdict from the mismatch count of the checker beside it.
// ----------------------------------------------------------------------------
module two_channel_chained_dma_controller_tb;
  import dmac_pkg::*;

  // clock, reset and run shape
  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 11;
  localparam int RANDOM_REQUESTS = 800;
  localparam int IDLE_PERCENT    = 23;
  localparam int HOLD_CYCLES     = 80;
  localparam int DRAIN_CYCLES    = 16;
  localparam int WATCHDOG_LIMIT  = 2000;

  // windows of the random part, counted in requests
  localparam int HOLD_START   = 250;
  localparam int PAUSE_POINT  = 330;
  localparam int STEADY_START = 500;
  localparam int STEADY_END   = 650;

  // offsets past the count high register select nothing
  localparam logic [2:0] SEL_SPARE_FIRST = 3'd5;
  localparam logic [2:0] SEL_SPARE_LAST  = 3'd7;

  localparam logic CH0 = 1'b0;
  localparam logic CH1 = 1'b1;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          in_opcode;
  logic [OFF_W-1:0]    in_reg_offset;
  logic [DATA_W-1:0]   in_write_data;
  logic                in_req_channel;
  logic                in_req_level;
  logic                out_valid;
  logic                out_ready;
  logic [DATA_W-1:0]   out_read_data;
  logic                out_request_edge;
  logic                out_xfer_valid;
  logic                out_xfer_channel;
  logic                out_xfer_to_memory;
  logic [PERIPH_W-1:0] out_xfer_peripheral;
  logic [ADDR_W-1:0]   out_xfer_address;
  logic [CNT_W-1:0]    out_xfer_count_before;
  logic                out_done_irq;
  logic                out_last;
  int                  mismatches;
  int                  outstanding;

  // knobs shared between the request side and the result side
  bit sender_gaps  = 1'b1;
  bit sink_stalls  = 1'b1;
  bit hold_results = 1'b0;
  int requests_sent = 0;
  int quiet_cycles  = 0;

  two_channel_chained_dma_controller uut (.*);

  two_channel_chained_dma_controller_checker dma_checker (.*);

  initial clk = 1'b0;
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // result side: random stalls, plus one long hold-off on demand so the
  // controller fills up and pushes back on its input
  initial begin : result_sink
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end
      out_ready <= !sink_stalls || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // watchdog: too long with neither channel moving ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("two_channel_chained_dma_controller verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offers one request and returns at the edge that takes it; valid stays
  // high across back-to-back requests and only drops for a gap
  task automatic send_request(input opcode_t op, input logic [OFF_W-1:0] off,
                              input logic [DATA_W-1:0] data, input logic rc,
                              input logic lvl);
    bit taken;
    if (sender_gaps) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_reg_offset  <= off;
    in_write_data  <= data;
    in_req_channel <= rc;
    in_req_level   <= lvl;
    // inputs only move at rising edges, so ready is settled by the falling one
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    requests_sent++;
  endtask

  // unused fields of each request carry random bits
  task automatic write_reg(input logic ch, input logic [2:0] sel,
                           input logic [DATA_W-1:0] data);
    send_request(OP_WRITE, {ch, sel}, data, 1'($urandom), 1'($urandom));
  endtask

  task automatic read_reg(input logic ch, input logic [2:0] sel);
    send_request(OP_READ, {ch, sel}, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic change_request(input logic ch, input logic lvl);
    send_request(OP_REQ, 4'($urandom), 8'($urandom), ch, lvl);
  endtask

  task automatic beat();
    send_request(OP_BEAT, 4'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  initial begin : stimulus
    bit               hold_done;
    bit               pause_done;
    int               first_random;
    int               progress;
    int               beats;
    logic             ch;
    logic [CTL_W-1:0] ctl_byte;
    hold_done      = 1'b0;
    pause_done     = 1'b0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_opcode      <= OP_READ;
    in_reg_offset  <= '0;
    in_write_data  <= '0;
    in_req_channel <= 1'b0;
    in_req_level   <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // control reads zero after reset
    read_reg(CH0, SEL_CTL);
    // channel 0 at the top of memory with one transfer left; only the low
    // three bits of a count high write stick
    write_reg(CH0, SEL_ADDR_LO, 8'hFF);
    write_reg(CH0, SEL_ADDR_HI, 8'hFF);
    write_reg(CH0, SEL_CNT_LO, 8'h01);
    write_reg(CH0, SEL_CNT_HI, 8'hF8);
    // every control bit set; the request bit must not follow the write
    write_reg(CH0, SEL_CTL, 8'hFF);
    read_reg(CH0, SEL_CTL);
    // request line rises, then the same level again with no edge
    change_request(CH0, 1'b1);
    change_request(CH0, 1'b1);
    // channel 1 at the largest count, waiting for a chained enable
    write_reg(CH1, SEL_CNT_LO, 8'hFF);
    write_reg(CH1, SEL_CNT_HI, 8'hFF);
    write_reg(CH1, SEL_CTL, 8'h08);
    change_request(CH1, 1'b1);
    // channel 0 finishes and wraps, channel 1 runs in the same beat
    beat();
    read_reg(CH0, SEL_ADDR_HI);
    // spare offsets: write ignored, read zero
    write_reg(CH1, SEL_SPARE_LAST, 8'hFF);
    read_reg(CH1, SEL_SPARE_FIRST);
    // now chain the other way: channel 1 finishes, channel 0 waits a beat
    write_reg(CH0, SEL_CTL, 8'h08);
    write_reg(CH0, SEL_CNT_LO, 8'h02);
    write_reg(CH1, SEL_CNT_LO, 8'h01);
    write_reg(CH1, SEL_CNT_HI, 8'h00);
    beat();
    beat();
    // request dropped: beat with nothing to move
    change_request(CH0, 1'b0);
    beat();

    // --- random part ---
    first_random = requests_sent;
    while (requests_sent < first_random + RANDOM_REQUESTS) begin
      progress    = requests_sent - first_random;
      // a stretch with no idling on either side
      sink_stalls = !(progress >= STEADY_START && progress < STEADY_END);
      // keep offering while the result side holds off
      sender_gaps = sink_stalls && !(progress >= HOLD_START && progress < PAUSE_POINT);
      if (!hold_done && progress >= HOLD_START) begin
        hold_done    = 1'b1;
        hold_results = 1'b1;
      end
      if (!pause_done && progress >= PAUSE_POINT) begin
        pause_done = 1'b1;
        wait_for_drain();
      end
      if ($urandom_range(9) < 7) begin
        // program one channel, usually raise its request and run a few beats,
        // mostly with short counts so channels finish and chain
        ch       = 1'($urandom);
        ctl_byte = 8'($urandom);
        ctl_byte[CTL_EN_BIT] = ($urandom_range(9) != 0);
        write_reg(ch, SEL_CTL, ctl_byte);
        if ($urandom_range(1)) write_reg(ch, SEL_ADDR_LO, 8'($urandom));
        if ($urandom_range(1)) write_reg(ch, SEL_ADDR_HI, 8'($urandom));
        write_reg(ch, SEL_CNT_LO,
                  ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(6, 1)));
        write_reg(ch, SEL_CNT_HI,
                  ($urandom_range(15) == 0) ? 8'($urandom) : {5'($urandom), 3'b000});
        change_request(ch, $urandom_range(7) != 0);
        beats = $urandom_range(8, 1);
        repeat (beats) begin
          if ($urandom_range(4) == 0) read_reg(1'($urandom), 3'($urandom));
          beat();
        end
      end else begin
        // noise: any operation, any field
        send_request(opcode_t'($urandom_range(3)), 4'($urandom), 8'($urandom),
                     1'($urandom), 1'($urandom));
      end
    end

    // --- wind down ---
    sink_stalls = 1'b1;
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("two_channel_chained_dma_controller verification clean");
    end else begin
      $display("two_channel_chained_dma_controller verification failed");
    end
    $finish;
  end

endmodule
